// ===== design/sha512_compression_macros.svh =====
// assertion macros used by the sha-512 controller rtl
// expects clk and rst_n in the scope of the module that uses them
`ifndef SHA512_COMPRESSION_MACROS_SVH
`define SHA512_COMPRESSION_MACROS_SVH

// same-cycle implication, checked out of reset
`define SHA512_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SHA512_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sha512_pkg.sv =====
// shared types and constants of the sha-512 compression block
// no dependencies; used by sha512_ctrl, sha512_datapath and the top level
package sha512_pkg;

  localparam int WORD_W = 64;

  localparam logic [3:0] WORD_LAST  = 4'd15;
  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [2:0] EMIT_LAST  = 3'd7;

  typedef struct packed {
    logic [WORD_W-1:0] message_word;
    logic              new_message;
    logic              final_block;
  } sha512_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] digest_word;
    logic              digest_last;
  } sha512_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load_word;
    logic       init_hash;
    logic       start;
    logic       round_en;
    logic       fold;
    logic       emit_ld;
    logic [2:0] emit_idx;
    logic [6:0] round_idx;
  } sha512_cmd_t;

  localparam logic [WORD_W-1:0] INIT_HASH [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [WORD_W-1:0] ROUND_K [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

endpackage

// ===== design/sha512_ctrl.sv =====
// control state machine: word counting, round sequencing, digest output handshake
// depends on sha512_pkg and sha512_compression_macros.svh
`include "sha512_compression_macros.svh"

module sha512_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_new_message,
  input  logic                   in_final_block,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sha512_pkg::sha512_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_FOLD  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] word_cnt_r, word_cnt_nxt;
  logic [6:0] round_r, round_nxt;
  logic [2:0] emit_idx_r, emit_idx_nxt;
  logic       final_r, final_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       emit_ld;

  // output register free or being drained this cycle
  assign emit_ld   = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    word_cnt_nxt  = word_cnt_r;
    round_nxt     = round_r;
    emit_idx_nxt  = emit_idx_r;
    final_nxt     = final_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.round_idx = round_r;
    cmd.emit_idx  = emit_idx_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          cmd.load_word = 1'b1;
          cmd.init_hash = (word_cnt_r == '0) && in_new_message;
          word_cnt_nxt  = word_cnt_r + 4'd1;
          if (word_cnt_r == sha512_pkg::WORD_LAST) begin
            cmd.start = 1'b1;
            final_nxt = in_final_block;
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        if (round_r == sha512_pkg::ROUND_LAST) begin
          round_nxt = '0;
          state_nxt = ST_FOLD;
        end else begin
          round_nxt = round_r + 7'd1;
        end
      end
      ST_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = final_r ? ST_EMIT : ST_LOAD;
      end
      ST_EMIT: begin
        if (emit_ld) begin
          cmd.emit_ld   = 1'b1;
          out_valid_nxt = 1'b1;
          emit_idx_nxt  = emit_idx_r + 3'd1;
          if (emit_idx_r == sha512_pkg::EMIT_LAST) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      word_cnt_r  <= '0;
      round_r     <= '0;
      emit_idx_r  <= '0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      word_cnt_r  <= word_cnt_nxt;
      round_r     <= round_nxt;
      emit_idx_r  <= emit_idx_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SHA512_ASSERT_NOW(a_round_idle, state_r != ST_ROUND, round_r == '0, "round count left nonzero")
  `SHA512_ASSERT_NOW(a_emit_idle, state_r != ST_EMIT, emit_idx_r == '0, "digest index left nonzero")
  `SHA512_ASSERT_NOW(a_words_idle, state_r != ST_LOAD, word_cnt_r == '0, "word count nonzero off load")
  `SHA512_ASSERT_NEXT(a_block_start, in_valid && in_ready && word_cnt_r == sha512_pkg::WORD_LAST, state_r == ST_ROUND, "full block did not start rounds")
  `SHA512_ASSERT_NEXT(a_last_digest, state_r == ST_EMIT && emit_ld && emit_idx_r == sha512_pkg::EMIT_LAST, state_r == ST_LOAD && out_valid_r, "last digest beat not presented")

endmodule

// ===== design/sha512_datapath.sv =====
// datapath: schedule window, working variables, chaining hash, digest register
// depends on sha512_pkg; driven by commands from sha512_ctrl
module sha512_datapath (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sha512_pkg::sha512_cmd_t cmd,
  input  logic [63:0]             message_word,
  output sha512_pkg::sha512_out_t out_data
);

  logic [63:0] hash_r [8];
  logic [63:0] vars_r [8];
  logic [63:0] vars_nxt [8];
  logic [63:0] win_r [16];
  logic [63:0] w_new, t1, t2, w_cur;
  sha512_pkg::sha512_out_t out_r;

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] bsig0(input logic [63:0] x);
    bsig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic logic [63:0] bsig1(input logic [63:0] x);
    bsig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic logic [63:0] ssig0(input logic [63:0] x);
    ssig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [63:0] ssig1(input logic [63:0] x);
    ssig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

  // window holds w[t..t+15] during round t
  assign w_cur = win_r[0];
  assign w_new = ssig1(win_r[14]) + win_r[9] + ssig0(win_r[1]) + win_r[0];

  assign t1 = vars_r[7] + bsig1(vars_r[4])
            + ((vars_r[4] & vars_r[5]) ^ (~vars_r[4] & vars_r[6]))
            + sha512_pkg::ROUND_K[cmd.round_idx] + w_cur;
  assign t2 = bsig0(vars_r[0])
            + ((vars_r[0] & vars_r[1]) ^ (vars_r[0] & vars_r[2]) ^ (vars_r[1] & vars_r[2]));

  always_comb begin
    vars_nxt[0] = t1 + t2;
    vars_nxt[1] = vars_r[0];
    vars_nxt[2] = vars_r[1];
    vars_nxt[3] = vars_r[2];
    vars_nxt[4] = vars_r[3] + t1;
    vars_nxt[5] = vars_r[4];
    vars_nxt[6] = vars_r[5];
    vars_nxt[7] = vars_r[6];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= sha512_pkg::INIT_HASH;
    end else if (cmd.init_hash) begin
      hash_r <= sha512_pkg::INIT_HASH;
    end else if (cmd.fold) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= hash_r[i] + vars_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      vars_r <= hash_r;
    end else if (cmd.round_en) begin
      vars_r <= vars_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_word || cmd.round_en) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= cmd.load_word ? message_word : w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      out_r.digest_word <= hash_r[cmd.emit_idx];
      out_r.digest_last <= (cmd.emit_idx == sha512_pkg::EMIT_LAST);
    end
  end

  assign out_data = out_r;

endmodule

// ===== design/sha512_compression.sv =====
// channel  | dir | payload                                  | handshake
// in_      | in  | message_word, new_message, final_block   | in_valid / in_ready
// out_     | out | digest_word, digest_last                 | out_valid / out_ready
//
// a 16-word block takes 16 accept beats, then 80 rounds on the single round
// unit and a fold of the working variables into the chaining hash
// a final block adds 8 digest beats from the output register, one per cycle unstalled
// in_ready is high only while words are being collected; out_ready stalls digest beats
// rst_n (synchronous, active low) loads the initial hash and idles the controller
// depends on sha512_pkg, sha512_ctrl, sha512_datapath
module sha512_compression (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  sha512_pkg::sha512_in_t  in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output sha512_pkg::sha512_out_t out_data
);

  sha512_pkg::sha512_cmd_t cmd;

  sha512_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_new_message (in_data.new_message),
    .in_final_block (in_data.final_block),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cmd            (cmd)
  );

  sha512_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .message_word (in_data.message_word),
    .out_data     (out_data)
  );

endmodule
